@@ sv/pose_relative_fov_point_crop_core_assert.svh @@
// Assertion macros shared by the crop core.
`ifndef POSE_RELATIVE_FOV_POINT_CROP_CORE_ASSERT_SVH
`define POSE_RELATIVE_FOV_POINT_CROP_CORE_ASSERT_SVH

// Same-cycle implication.
`define PFC_ASSERT_IMPL(label, clk_s, rstn_s, pre, post) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (pre) |-> (post)) \
        else $error("pose crop core check failed");

// Next-cycle implication.
`define PFC_ASSERT_NEXT(label, clk_s, rstn_s, pre, post) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (pre) |=> (post)) \
        else $error("pose crop core check failed");

`endif

@@ sv/pfc_pkg.sv @@
`timescale 1ns / 1ps
package pfc_pkg;

    localparam int STEP_W     = 5;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 48;

    typedef enum logic [3:0] {
        CFG_ROT_ROW0 = 4'd0,
        CFG_ROT_ROW1 = 4'd1,
        CFG_ROT_ROW2 = 4'd2,
        CFG_SHIFT_X  = 4'd3,
        CFG_SHIFT_Y  = 4'd4,
        CFG_SHIFT_Z  = 4'd5,
        CFG_FAR      = 4'd6,
        CFG_FOV      = 4'd7
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_QPROD,
        S_QENT,
        S_COMP,
        S_TRANS,
        S_INV,
        S_PT,
        S_ABS,
        S_ABS_WAIT,
        S_SQ,
        S_SQ_WAIT,
        S_CHECK,
        S_CORDIC,
        S_DECIDE,
        S_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_QPROD,
        OP_QENT,
        OP_COMP,
        OP_TRANS,
        OP_INV,
        OP_PT,
        OP_ABS,
        OP_SQ,
        OP_FSQ
    } op_t;

    typedef struct packed {
        logic              load;
        op_t               op;
        logic [3:0]        idx;
        logic [1:0]        k;
        logic              cordic_init;
        logic              cordic_step;
        logic [STEP_W-1:0] step;
        logic              emit;
    } cmd_t;

    typedef struct packed {
        logic range_ok;
        logic at_origin;
        logic angle_ok;
        logic result_busy;
    } status_t;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
    } item_t;

    typedef struct packed {
        logic signed [31:0] kept_x;
        logic signed [31:0] kept_y;
        logic signed [31:0] kept_z;
    } result_t;

    localparam logic signed [16:0] HALF_PI_Q13 = 17'sd12868;

    function automatic logic [14:0] atan_q13(input logic [STEP_W-1:0] i);
        logic [14:0] v;
        unique case (i)
            5'd0:    v = 15'd6434;
            5'd1:    v = 15'd3798;
            5'd2:    v = 15'd2007;
            5'd3:    v = 15'd1019;
            5'd4:    v = 15'd511;
            5'd5:    v = 15'd256;
            5'd6:    v = 15'd128;
            5'd7:    v = 15'd64;
            5'd8:    v = 15'd32;
            5'd9:    v = 15'd16;
            5'd10:   v = 15'd8;
            5'd11:   v = 15'd4;
            5'd12:   v = 15'd2;
            5'd13:   v = 15'd1;
            default: v = 15'd0;
        endcase
        return v;
    endfunction

    // Row and column of a row-major 3x3 entry index.
    function automatic logic [1:0] idx_row(input logic [3:0] idx);
        logic [1:0] r;
        unique case (idx)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] idx_col(input logic [3:0] idx);
        logic [1:0] c;
        unique case (idx)
            4'd0, 4'd3, 4'd6: c = 2'd0;
            4'd1, 4'd4, 4'd7: c = 2'd1;
            default:          c = 2'd2;
        endcase
        return c;
    endfunction

endpackage

@@ sv/pfc_ctrl.sv @@
`timescale 1ns / 1ps
module pfc_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_kind,
    output logic             item_stall,
    output pfc_pkg::cmd_t    cmd,
    input  pfc_pkg::status_t status
);

    pfc_pkg::state_t state_reg, state_next;
    logic [3:0] idx_reg, idx_next, idx_last;
    logic [1:0] k_reg, k_next, k_last;
    logic [pfc_pkg::STEP_W-1:0] step_reg, step_next;
    logic loop_state;
    logic phase_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfc_pkg::S_IDLE;
            idx_reg   <= '0;
            k_reg     <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            k_reg     <= k_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        idx_last   = 4'd0;
        k_last     = 2'd0;
        loop_state = 1'b1;
        unique case (state_reg)
            pfc_pkg::S_QPROD, pfc_pkg::S_QENT: idx_last = 4'd8;
            pfc_pkg::S_COMP:
            begin
                idx_last = 4'd8;
                k_last   = 2'd2;
            end
            pfc_pkg::S_TRANS, pfc_pkg::S_INV:
            begin
                idx_last = 4'd2;
                k_last   = 2'd2;
            end
            pfc_pkg::S_PT:
            begin
                idx_last = 4'd1;
                k_last   = 2'd2;
            end
            pfc_pkg::S_SQ: k_last = 2'd2;
            default: loop_state = 1'b0;
        endcase
        phase_done = (idx_reg == idx_last) && (k_reg == k_last);

        idx_next = 4'd0;
        k_next   = 2'd0;
        if (loop_state && !phase_done)
        begin
            if (k_reg == k_last)
            begin
                idx_next = idx_reg + 4'd1;
            end
            else
            begin
                idx_next = idx_reg;
                k_next   = k_reg + 2'd1;
            end
        end

        step_next = (state_reg == pfc_pkg::S_CORDIC) ? step_reg + 1'b1 : '0;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pfc_pkg::S_IDLE:
                if (item_valid)
                    state_next = item_kind ? pfc_pkg::S_PT : pfc_pkg::S_QPROD;
            pfc_pkg::S_QPROD:    if (phase_done) state_next = pfc_pkg::S_QENT;
            pfc_pkg::S_QENT:     if (phase_done) state_next = pfc_pkg::S_COMP;
            pfc_pkg::S_COMP:     if (phase_done) state_next = pfc_pkg::S_TRANS;
            pfc_pkg::S_TRANS:    if (phase_done) state_next = pfc_pkg::S_INV;
            pfc_pkg::S_INV:      if (phase_done) state_next = pfc_pkg::S_IDLE;
            pfc_pkg::S_PT:       if (phase_done) state_next = pfc_pkg::S_ABS;
            pfc_pkg::S_ABS:      state_next = pfc_pkg::S_ABS_WAIT;
            pfc_pkg::S_ABS_WAIT: state_next = pfc_pkg::S_SQ;
            pfc_pkg::S_SQ:       if (phase_done) state_next = pfc_pkg::S_SQ_WAIT;
            pfc_pkg::S_SQ_WAIT:  state_next = pfc_pkg::S_CHECK;
            pfc_pkg::S_CHECK:
            begin
                priority if (!status.range_ok)
                    state_next = pfc_pkg::S_IDLE;
                else if (status.at_origin)
                    state_next = pfc_pkg::S_EMIT;
                else
                    state_next = pfc_pkg::S_CORDIC;
            end
            pfc_pkg::S_CORDIC:
                if (step_reg == pfc_pkg::STEP_W'(CORDIC_STEPS - 1))
                    state_next = pfc_pkg::S_DECIDE;
            pfc_pkg::S_DECIDE:
                state_next = status.angle_ok ? pfc_pkg::S_EMIT : pfc_pkg::S_IDLE;
            pfc_pkg::S_EMIT:     if (!status.result_busy) state_next = pfc_pkg::S_IDLE;
            default:             state_next = pfc_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        item_stall      = (state_reg != pfc_pkg::S_IDLE);
        cmd.load        = (state_reg == pfc_pkg::S_IDLE) && item_valid;
        cmd.idx         = idx_reg;
        cmd.k           = k_reg;
        cmd.cordic_init = (state_reg == pfc_pkg::S_CHECK);
        cmd.cordic_step = (state_reg == pfc_pkg::S_CORDIC);
        cmd.step        = step_reg;
        cmd.emit        = (state_reg == pfc_pkg::S_EMIT) && !status.result_busy;
        unique case (state_reg)
            pfc_pkg::S_QPROD: cmd.op = pfc_pkg::OP_QPROD;
            pfc_pkg::S_QENT:  cmd.op = pfc_pkg::OP_QENT;
            pfc_pkg::S_COMP:  cmd.op = pfc_pkg::OP_COMP;
            pfc_pkg::S_TRANS: cmd.op = pfc_pkg::OP_TRANS;
            pfc_pkg::S_INV:   cmd.op = pfc_pkg::OP_INV;
            pfc_pkg::S_PT:    cmd.op = pfc_pkg::OP_PT;
            pfc_pkg::S_ABS:   cmd.op = pfc_pkg::OP_ABS;
            pfc_pkg::S_SQ:    cmd.op = (k_reg == 2'd2) ? pfc_pkg::OP_FSQ : pfc_pkg::OP_SQ;
            default:          cmd.op = pfc_pkg::OP_NONE;
        endcase
    end

endmodule

@@ sv/pfc_dp.sv @@
`timescale 1ns / 1ps
module pfc_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [pfc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pfc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  pfc_pkg::item_t                  item,
    input  pfc_pkg::cmd_t                   cmd,
    output pfc_pkg::status_t                status,
    output logic                            result_valid,
    input  logic                            result_stall,
    output pfc_pkg::result_t                result
);

    localparam logic signed [63:0] RND14 = 64'sd8192;

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767)
            r = 16'sh7FFF;
        else if (v < -64'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [35:0] ext36(input logic signed [31:0] v);
        return $signed({{4{v[31]}}, v});
    endfunction

    // Configuration and persistent transform
    logic [47:0]        guess_row_reg [3];
    logic signed [31:0] gs_reg [3];
    logic [30:0]        far_reg;
    logic [15:0]        fov_reg;
    logic signed [15:0] ir_reg [3][3];
    logic signed [31:0] is_reg [3];

    // Working registers
    logic signed [15:0] quat_reg [4];
    logic signed [31:0] coord_reg [3];
    logic signed [31:0] qp_reg [9];
    logic signed [15:0] o_reg [3][3];
    logic signed [15:0] m_reg [3][3];
    logic signed [31:0] t_reg [3];
    pfc_pkg::op_t       s2_op_reg;
    logic [3:0]         s2_idx_reg;
    logic [1:0]         s2_k_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic signed [35:0] bx_reg, by_reg;
    logic [30:0]        ax_reg, ay_reg;
    logic               huge_reg;
    logic [62:0]        d2_reg;
    logic [61:0]        f2_reg;
    logic signed [35:0] cx_reg, cy_reg;
    logic signed [16:0] cz_reg;
    logic               res_valid_reg;
    pfc_pkg::result_t   res_reg;

    logic signed [15:0] g_ent [3][3];
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_full;
    logic [1:0]         qa, qb, r_sel, c_sel, s2_row, s2_col;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                g_ent[r][c] = guess_row_reg[r][16*c +: 16];
    end

    // Multiplier operand selection
    always_comb
    begin
        r_sel = pfc_pkg::idx_row(cmd.idx);
        c_sel = pfc_pkg::idx_col(cmd.idx);
        unique case (cmd.idx)
            4'd0:    begin qa = 2'd1; qb = 2'd1; end
            4'd1:    begin qa = 2'd2; qb = 2'd2; end
            4'd2:    begin qa = 2'd3; qb = 2'd3; end
            4'd3:    begin qa = 2'd1; qb = 2'd2; end
            4'd4:    begin qa = 2'd1; qb = 2'd3; end
            4'd5:    begin qa = 2'd2; qb = 2'd3; end
            4'd6:    begin qa = 2'd0; qb = 2'd1; end
            4'd7:    begin qa = 2'd0; qb = 2'd2; end
            default: begin qa = 2'd0; qb = 2'd3; end
        endcase
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            pfc_pkg::OP_QPROD:
            begin
                mul_a = $signed({{17{quat_reg[qa][15]}}, quat_reg[qa]});
                mul_b = $signed({{17{quat_reg[qb][15]}}, quat_reg[qb]});
            end
            pfc_pkg::OP_COMP:
            begin
                mul_a = $signed({{17{g_ent[r_sel][cmd.k][15]}}, g_ent[r_sel][cmd.k]});
                mul_b = $signed({{17{o_reg[cmd.k][c_sel][15]}}, o_reg[cmd.k][c_sel]});
            end
            pfc_pkg::OP_TRANS:
            begin
                mul_a = $signed({{17{g_ent[cmd.idx[1:0]][cmd.k][15]}},
                                 g_ent[cmd.idx[1:0]][cmd.k]});
                mul_b = $signed({coord_reg[cmd.k][31], coord_reg[cmd.k]});
            end
            pfc_pkg::OP_INV:
            begin
                mul_a = $signed({{17{m_reg[cmd.k][cmd.idx[1:0]][15]}},
                                 m_reg[cmd.k][cmd.idx[1:0]]});
                mul_b = $signed({t_reg[cmd.k][31], t_reg[cmd.k]});
            end
            pfc_pkg::OP_PT:
            begin
                mul_a = $signed({{17{ir_reg[cmd.idx[1:0]][cmd.k][15]}},
                                 ir_reg[cmd.idx[1:0]][cmd.k]});
                mul_b = $signed({coord_reg[cmd.k][31], coord_reg[cmd.k]});
            end
            pfc_pkg::OP_SQ:
            begin
                mul_a = (cmd.k == 2'd0) ? $signed({2'b00, ax_reg}) : $signed({2'b00, ay_reg});
                mul_b = mul_a;
            end
            pfc_pkg::OP_FSQ:
            begin
                mul_a = $signed({2'b00, far_reg});
                mul_b = mul_a;
            end
            default: ;
        endcase
        prod_full = mul_a * mul_b;
    end

    // Accumulate stage
    logic               s2_last;
    logic signed [63:0] init_val, sum, shifted;
    logic signed [35:0] term_a, term_b, o_base, o_val, o_rnd;
    logic signed [35:0] abs_x, abs_y;

    always_comb
    begin
        s2_row = pfc_pkg::idx_row(s2_idx_reg);
        s2_col = pfc_pkg::idx_col(s2_idx_reg);
        unique case (s2_op_reg)
            pfc_pkg::OP_COMP, pfc_pkg::OP_TRANS, pfc_pkg::OP_INV, pfc_pkg::OP_PT:
                s2_last = (s2_k_reg == 2'd2);
            pfc_pkg::OP_SQ: s2_last = (s2_k_reg == 2'd1);
            default:        s2_last = 1'b1;
        endcase
        // Rounding and the added shift are folded into the starting value; a square sum starts at zero.
        unique case (s2_op_reg)
            pfc_pkg::OP_TRANS:
                init_val = $signed({{18{gs_reg[s2_idx_reg[1:0]][31]}},
                                    gs_reg[s2_idx_reg[1:0]], 14'd0}) + RND14;
            pfc_pkg::OP_PT:
                init_val = $signed({{18{is_reg[s2_idx_reg[1:0]][31]}},
                                    is_reg[s2_idx_reg[1:0]], 14'd0}) + RND14;
            pfc_pkg::OP_SQ: init_val = '0;
            default:        init_val = RND14;
        endcase
        sum     = ((s2_k_reg == 2'd0) ? init_val : acc_reg) + prod_reg;
        shifted = sum >>> 14;

        o_base = 36'sd0;
        unique case (s2_idx_reg)
            4'd0:
            begin
                o_base = 36'sd268435456;
                term_a = -ext36(qp_reg[1]);
                term_b = -ext36(qp_reg[2]);
            end
            4'd1:    begin term_a = ext36(qp_reg[3]); term_b = -ext36(qp_reg[8]); end
            4'd2:    begin term_a = ext36(qp_reg[4]); term_b = ext36(qp_reg[7]); end
            4'd3:    begin term_a = ext36(qp_reg[3]); term_b = ext36(qp_reg[8]); end
            4'd4:
            begin
                o_base = 36'sd268435456;
                term_a = -ext36(qp_reg[0]);
                term_b = -ext36(qp_reg[2]);
            end
            4'd5:    begin term_a = ext36(qp_reg[5]); term_b = -ext36(qp_reg[6]); end
            4'd6:    begin term_a = ext36(qp_reg[4]); term_b = -ext36(qp_reg[7]); end
            4'd7:    begin term_a = ext36(qp_reg[5]); term_b = ext36(qp_reg[6]); end
            default:
            begin
                o_base = 36'sd268435456;
                term_a = -ext36(qp_reg[0]);
                term_b = -ext36(qp_reg[1]);
            end
        endcase
        o_val = o_base + ((term_a + term_b) <<< 1);
        o_rnd = (o_val + 36'sd8192) >>> 14;

        abs_x = bx_reg[35] ? -bx_reg : bx_reg;
        abs_y = by_reg[35] ? -by_reg : by_reg;
    end

    // CORDIC and final decisions
    logic signed [35:0] dx, dy;
    logic signed [16:0] atan_v, lim;

    always_comb
    begin
        dx     = cy_reg >>> cmd.step;
        dy     = cx_reg >>> cmd.step;
        atan_v = $signed({2'b00, pfc_pkg::atan_q13(cmd.step)});
        lim    = cz_reg[16] ? -cz_reg : cz_reg;
        status.range_ok    = !huge_reg && (d2_reg <= {1'b0, f2_reg});
        status.at_origin   = (bx_reg == 36'sd0) && (by_reg == 36'sd0);
        status.angle_ok    = ({lim, 1'b0} <= {2'b00, fov_reg});
        status.result_busy = res_valid_reg && result_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            guess_row_reg[0] <= 48'h0000_0000_4000;
            guess_row_reg[1] <= 48'h0000_4000_0000;
            guess_row_reg[2] <= 48'h4000_0000_0000;
            for (int r = 0; r < 3; r++)
            begin
                gs_reg[r] <= '0;
                is_reg[r] <= '0;
                for (int c = 0; c < 3; c++)
                    ir_reg[r][c] <= (r == c) ? 16'sd16384 : 16'sd0;
            end
            far_reg       <= 31'h7FFF_FFFF;
            fov_reg       <= 16'd51472;
            s2_op_reg     <= pfc_pkg::OP_NONE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    pfc_pkg::CFG_ROT_ROW0: guess_row_reg[0] <= cfg_data;
                    pfc_pkg::CFG_ROT_ROW1: guess_row_reg[1] <= cfg_data;
                    pfc_pkg::CFG_ROT_ROW2: guess_row_reg[2] <= cfg_data;
                    pfc_pkg::CFG_SHIFT_X:  gs_reg[0] <= cfg_data[31:0];
                    pfc_pkg::CFG_SHIFT_Y:  gs_reg[1] <= cfg_data[31:0];
                    pfc_pkg::CFG_SHIFT_Z:  gs_reg[2] <= cfg_data[31:0];
                    pfc_pkg::CFG_FAR:      far_reg <= cfg_data[30:0];
                    pfc_pkg::CFG_FOV:      fov_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s2_op_reg == pfc_pkg::OP_INV)
            begin
                // The inverse rotation is the transpose of the composed one.
                ir_reg[s2_idx_reg[1:0]][s2_k_reg] <= m_reg[s2_k_reg][s2_idx_reg[1:0]];
                if (s2_last)
                    is_reg[s2_idx_reg[1:0]] <= sat32(-shifted);
            end
            s2_op_reg <= cmd.op;
            if (cmd.emit)
                res_valid_reg <= 1'b1;
            else if (!result_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_idx_reg <= cmd.idx;
        s2_k_reg   <= cmd.k;
        prod_reg   <= prod_full[63:0];
        if (cmd.load)
        begin
            quat_reg[0]  <= item.quat_w;
            quat_reg[1]  <= item.quat_x;
            quat_reg[2]  <= item.quat_y;
            quat_reg[3]  <= item.quat_z;
            coord_reg[0] <= item.coord_x;
            coord_reg[1] <= item.coord_y;
            coord_reg[2] <= item.coord_z;
        end
        unique case (s2_op_reg)
            pfc_pkg::OP_QPROD: qp_reg[s2_idx_reg] <= prod_reg[31:0];
            pfc_pkg::OP_QENT:
                o_reg[s2_row][s2_col] <= sat16($signed({{28{o_rnd[35]}}, o_rnd}));
            pfc_pkg::OP_COMP:
            begin
                acc_reg <= sum;
                if (s2_last)
                    m_reg[s2_row][s2_col] <= sat16(shifted);
            end
            pfc_pkg::OP_TRANS:
            begin
                acc_reg <= sum;
                if (s2_last)
                    t_reg[s2_idx_reg[1:0]] <= sat32(shifted);
            end
            pfc_pkg::OP_INV: acc_reg <= sum;
            pfc_pkg::OP_PT:
            begin
                acc_reg <= sum;
                if (s2_last)
                begin
                    if (s2_idx_reg[0])
                        by_reg <= shifted[35:0];
                    else
                        bx_reg <= shifted[35:0];
                end
            end
            pfc_pkg::OP_ABS:
            begin
                ax_reg   <= abs_x[30:0];
                ay_reg   <= abs_y[30:0];
                huge_reg <= (abs_x[35:31] != 5'd0) || (abs_y[35:31] != 5'd0);
            end
            pfc_pkg::OP_SQ:
            begin
                acc_reg <= sum;
                if (s2_last)
                    d2_reg <= sum[62:0];
            end
            pfc_pkg::OP_FSQ: f2_reg <= prod_reg[61:0];
            default: ;
        endcase
        if (cmd.cordic_init)
        begin
            priority if (bx_reg[35] && !by_reg[35])
            begin
                cx_reg <= by_reg;
                cy_reg <= -bx_reg;
                cz_reg <= pfc_pkg::HALF_PI_Q13;
            end
            else if (bx_reg[35])
            begin
                cx_reg <= -by_reg;
                cy_reg <= bx_reg;
                cz_reg <= -pfc_pkg::HALF_PI_Q13;
            end
            else
            begin
                cx_reg <= bx_reg;
                cy_reg <= by_reg;
                cz_reg <= 17'sd0;
            end
        end
        else if (cmd.cordic_step)
        begin
            if (!cy_reg[35])
            begin
                cx_reg <= cx_reg + dx;
                cy_reg <= cy_reg - dy;
                cz_reg <= cz_reg + atan_v;
            end
            else
            begin
                cx_reg <= cx_reg - dx;
                cy_reg <= cy_reg + dy;
                cz_reg <= cz_reg - atan_v;
            end
        end
        if (cmd.emit)
        begin
            res_reg.kept_x <= coord_reg[0];
            res_reg.kept_y <= coord_reg[1];
            res_reg.kept_z <= coord_reg[2];
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

@@ sv/pose_relative_fov_point_crop_core.sv @@
`timescale 1ns / 1ps
`include "pose_relative_fov_point_crop_core_assert.svh"
// Pose-relative field-of-view crop for map points.
// The item channel (item_valid / item_stall / item) carries pose updates
// (kind 0) and map points (kind 1). A pose item rebuilds the stored inverse
// transform and produces no result. A point item is moved into the body
// frame and, if kept, is returned unchanged on the result channel
// (result_valid / result_stall / result).
// The block works on one item at a time on a single shared multiplier.
// A point item is dropped when it fails the range test and kept at the origin;
// otherwise the bearing test decides, one CORDIC iteration per cycle.
// A kept point sits in the result register until its transfer completes;
// while the receiver stalls, the next item is already taken and processed,
// and it waits only at the point where its own result would be written.
// Configuration writes (cfg_valid / cfg_ready / cfg_index / cfg_data) are
// accepted every cycle; indexes beyond the register list are ignored.
// Reset restores the register defaults and an identity pose.
module pose_relative_fov_point_crop_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  pfc_pkg::item_t                  item,
    output logic                            result_valid,
    input  logic                            result_stall,
    output pfc_pkg::result_t                result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pfc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pfc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    pfc_pkg::cmd_t    cmd;
    pfc_pkg::status_t status;

    assign cfg_ready = 1'b1;

    pfc_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_valid(item_valid),
        .item_kind (item.kind),
        .item_stall(item_stall),
        .cmd       (cmd),
        .status    (status)
    );

    pfc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item        (item),
        .cmd         (cmd),
        .status      (status),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result)
    );

    `PFC_ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, item_valid && !item_stall, item_stall)
    `PFC_ASSERT_IMPL(a_no_result_overwrite, clk, rst_n, cmd.emit, !(result_valid && result_stall))
    `PFC_ASSERT_NEXT(a_valid_only_from_emit, clk, rst_n, !cmd.emit && !result_valid, !result_valid)

endmodule
